// ===== rtl/sha_pkg.sv =====
// sha-256 core shared types and constants
// used by sha_ctrl, sha_dp and sha256_hash_core; no dependencies
package sha_pkg;

  localparam int unsigned WordW = 32;

  // digest word count
  localparam int unsigned DigestWords = 8;

  // initial hash value
  localparam logic [WordW-1:0] InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // source of the word pushed into the schedule window
  typedef enum logic [2:0] {
    SRC_MSG  = 3'b000,
    SRC_MARK = 3'b001,
    SRC_ZERO = 3'b010,
    SRC_LENH = 3'b011,
    SRC_LENL = 3'b100
  } push_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic      push;       // write one word into the window
    push_src_t src;
    logic      add_len;    // add message bytes to bit length
    logic      comp_init;  // load working vars from chaining value
    logic      round;      // run one compression round
    logic      comp_fold;  // add working vars into chaining value
    logic      restart;    // chaining value, position, length to reset values
    logic      out_load;   // load digest word into output register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       block_full;  // next push fills the block
    logic [3:0] pos;
    logic [5:0] rnd;
    logic [2:0] out_idx;
  } dp_stat_t;

endpackage

// ===== rtl/sha_dp.sv =====
// sha-256 datapath: window, working vars, chaining value, length, output register
// depends on sha_pkg
module sha_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          msg_word,
  input  logic [2:0]           msg_bytes,
  input  logic                 msg_last,
  input  sha_pkg::dp_cmd_t     cmd,
  output sha_pkg::dp_stat_t    stat,
  output logic [31:0]          dig_word,
  output logic [2:0]           dig_idx
);
  import sha_pkg::*;

  logic [31:0] win_r [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] h_r [8];
  logic [3:0]  pos_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic [31:0] dig_r;
  logic [2:0]  didx_r;

  logic [2:0]  cnt;
  logic [31:0] keep, mark, msg_eff, push_w, wt, w_new;
  logic [31:0] s0, s1, ch, mj, t1, t2, g0, g1, w15, w2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

  // clamp byte count and form the final word with its marker
  always_comb begin
    cnt = (msg_bytes > 3'd4) ? 3'd4 : msg_bytes;
    if (!msg_last) cnt = 3'd4;
    case (cnt)
      3'd0: begin keep = 32'h0;        mark = 32'h80000000; end
      3'd1: begin keep = 32'hff000000; mark = 32'h00800000; end
      3'd2: begin keep = 32'hffff0000; mark = 32'h00008000; end
      3'd3: begin keep = 32'hffffff00; mark = 32'h00000080; end
      default: begin keep = 32'hffffffff; mark = 32'h0; end
    endcase
    msg_eff = (msg_word & keep) | (msg_last ? mark : 32'h0);
    case (cmd.src)
      SRC_MSG:  push_w = msg_eff;
      SRC_MARK: push_w = 32'h80000000;
      SRC_LENH: push_w = len_r[63:32];
      SRC_LENL: push_w = len_r[31:0];
      default:  push_w = 32'h0;
    endcase
  end

  // schedule word and round function
  always_comb begin
    w15 = win_r[rnd_r[3:0] + 4'd1];
    w2  = win_r[rnd_r[3:0] + 4'd14];
    g0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    g1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    w_new = win_r[rnd_r[3:0]] + g0 + win_r[rnd_r[3:0] + 4'd9] + g1;
    wt = rnd_r[5:4] == 2'd0 ? win_r[rnd_r[3:0]] : w_new;
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + RoundK[rnd_r] + wt;
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
    v_nxt[0] = t1 + t2;
    v_nxt[1] = v_r[0];
    v_nxt[2] = v_r[1];
    v_nxt[3] = v_r[2];
    v_nxt[4] = v_r[3] + t1;
    v_nxt[5] = v_r[4];
    v_nxt[6] = v_r[5];
    v_nxt[7] = v_r[6];
  end

  // control-state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 4'd0;
      len_r  <= 64'd0;
      rnd_r  <= 6'd0;
      oidx_r <= 3'd0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
    end else begin
      if (cmd.push) pos_r <= pos_r + 4'd1;
      if (cmd.add_len) len_r <= len_r + {58'd0, cnt, 3'd0};
      if (cmd.comp_init) rnd_r <= 6'd0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.comp_fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (cmd.out_load) oidx_r <= oidx_r + 3'd1;
      if (cmd.restart) begin
        pos_r  <= 4'd0;
        len_r  <= 64'd0;
        oidx_r <= 3'd0;
        for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push) win_r[pos_r] <= push_w;
    if (cmd.round && rnd_r[5:4] != 2'd0) win_r[rnd_r[3:0]] <= w_new;
    if (cmd.comp_init) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    else if (cmd.round) for (int i = 0; i < 8; i++) v_r[i] <= v_nxt[i];
    if (cmd.out_load) begin
      dig_r  <= h_r[oidx_r];
      didx_r <= oidx_r;
    end
  end

  assign stat.block_full = pos_r == 4'd15;
  assign stat.pos        = pos_r;
  assign stat.rnd        = rnd_r;
  assign stat.out_idx    = oidx_r;
  assign dig_word        = dig_r;
  assign dig_idx         = didx_r;

  // window and round updates never coincide
  a_push_round: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.round)) else $error("push during round");
  // length cleared after restart
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> len_r == 64'd0 && pos_r == 4'd0) else $error("restart failed");
  // fold only after the last round
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_fold |-> rnd_r == 6'd0 && $past(cmd.round)) else $error("early fold");
endmodule

// ===== rtl/sha_ctrl.sv =====
// sha-256 controller: intake, padding, compression sequencing, digest output
// depends on sha_pkg
module sha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  logic [2:0]           in_bytes,
  output logic                 in_rdy,
  input  logic                 out_rdy,
  output logic                 out_vld,
  output logic                 out_lst,
  input  sha_pkg::dp_stat_t    stat,
  output sha_pkg::dp_cmd_t     cmd
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COMP  = 7'b0000010,
    S_FOLD  = 7'b0000100,
    S_PAD   = 7'b0001000,
    S_LOAD  = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_MARK  = 7'b1000000
  } state_t;

  state_t    state_r, state_nxt;
  logic      fin_r, fin_nxt;      // message ended, padding in progress
  logic      mark_r, mark_nxt;    // marker word still owed
  logic      ovld_r, ovld_nxt;
  logic      olst_r, olst_nxt;
  push_src_t last_src_r;          // source of the most recent pushed word

  // input accepted only while idle
  assign in_rdy = state_r == S_IDLE;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    ovld_nxt  = ovld_r;
    olst_nxt  = olst_r;
    cmd       = '0;
    cmd.src   = SRC_MSG;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.push    = 1'b1;
          cmd.add_len = 1'b1;
          if (in_last) begin
            fin_nxt  = 1'b1;
            mark_nxt = in_bytes >= 3'd4;
          end
          if (stat.block_full) begin
            cmd.comp_init = 1'b1;
            state_nxt = S_COMP;
          end else if (in_last) begin
            state_nxt = in_bytes >= 3'd4 ? S_MARK : S_PAD;
          end
        end
      end
      S_MARK: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_MARK;
        mark_nxt = 1'b0;
        if (stat.block_full) begin
          cmd.comp_init = 1'b1;
          state_nxt = S_COMP;
        end else state_nxt = S_PAD;
      end
      S_PAD: begin
        cmd.push = 1'b1;
        if (stat.pos == 4'd14) cmd.src = SRC_LENH;
        else if (stat.pos == 4'd15 && last_src_r == SRC_LENH) cmd.src = SRC_LENL;
        else cmd.src = SRC_ZERO;
        if (stat.block_full) begin
          cmd.comp_init = 1'b1;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        if (stat.rnd == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.comp_fold = 1'b1;
        if (!fin_r) state_nxt = S_IDLE;
        else if (mark_r) state_nxt = S_MARK;
        else if (last_src_r == SRC_LENL) state_nxt = S_LOAD;
        else state_nxt = S_PAD;
      end
      S_LOAD: begin
        if (!ovld_r || out_rdy) begin
          cmd.out_load = 1'b1;
          ovld_nxt = 1'b1;
          olst_nxt = stat.out_idx == 3'd7;
          if (stat.out_idx == 3'd7) state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_rdy) begin
          ovld_nxt = 1'b0;
          olst_nxt = 1'b0;
          cmd.restart = 1'b1;
          fin_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // the length words went into the block just compressed once the low word was pushed
  always_ff @(posedge clk) begin
    if (!rst_n) last_src_r <= SRC_MSG;
    else if (cmd.push) last_src_r <= cmd.src;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      ovld_r  <= 1'b0;
      olst_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      ovld_r  <= ovld_nxt;
      olst_r  <= olst_nxt;
    end
  end

  assign out_vld = ovld_r;
  assign out_lst = olst_r;

  // no input taken while a digest is pending
  a_noin: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> !in_rdy) else $error("input during output");
  // last digest word only with valid
  a_lst: assert property (@(posedge clk) disable iff (!rst_n)
    out_lst |-> out_vld) else $error("last without valid");
  // compression entered from a full block only
  a_comp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_init |-> stat.pos == 4'd15) else $error("partial block");
endmodule

// ===== rtl/sha256_hash_core.sv =====
// sha-256 hash core top level: controller plus datapath
// depends on sha_pkg, sha_ctrl, sha_dp
// a word that fills a block starts compression (64 rounds, then fold), and no
// input is taken until the fold; other words are only written into the window;
// a block takes 16 intake pushes, 64 rounds and a fold, set by the single round unit;
// the last word adds padding pushes, one or two compressions and eight digest
// words, one per cycle while out_tready is high; synchronous active-low reset
// restores the initial hash, clears position and length
module sha256_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // message_word[31:0], byte_count[34:32], zero fill
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast   // digest_last
);
  import sha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_fire;
  logic [31:0] dig_word;
  logic [2:0]  dig_idx;

  assign in_fire = in_tvalid && in_tready;

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_tlast),
    .in_bytes(in_tdata[34:32]), .in_rdy(in_tready), .out_rdy(out_tready),
    .out_vld(out_tvalid), .out_lst(out_tlast), .stat(stat), .cmd(cmd)
  );

  sha_dp u_dp (
    .clk(clk), .rst_n(rst_n), .msg_word(in_tdata[31:0]),
    .msg_bytes(in_tdata[34:32]), .msg_last(in_tlast), .cmd(cmd),
    .stat(stat), .dig_word(dig_word), .dig_idx(dig_idx)
  );

  assign out_tdata = {5'd0, dig_idx, dig_word};
endmodule
